>>> hdl/limit_order_book_levels_top_defines.svh
// assertion helpers used by the book logic
`ifndef LIMIT_ORDER_BOOK_LEVELS_TOP_DEFINES_SVH
`define LIMIT_ORDER_BOOK_LEVELS_TOP_DEFINES_SVH

// checked only out of reset
`define LOB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define LOB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> hdl/lob_pkg.sv
package lob_pkg;

    localparam int ORDER_SLOTS     = 4096;
    localparam int ID_W            = $clog2(ORDER_SLOTS);
    localparam int LEVELS_PER_SIDE = 64;
    localparam int LVL_W           = $clog2(LEVELS_PER_SIDE);
    localparam int LCNT_W          = LVL_W + 1;
    localparam int PRICE_BITS      = 16;
    localparam int QCNT_W          = 13;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_CANCEL = 1'b1;
    localparam logic SIDE_BID    = 1'b0;
    localparam logic SIDE_ASK    = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_DUP     = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [11:0] order_id;
        logic        side;
        logic [15:0] price;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        bid_valid;
        logic [15:0] best_bid_price;
        logic [12:0] best_bid_count;
        logic [11:0] best_bid_head;
        logic        ask_valid;
        logic [15:0] best_ask_price;
        logic [12:0] best_ask_count;
        logic [11:0] best_ask_head;
    } out_item_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [QCNT_W-1:0]     count;
        logic [ID_W-1:0]       head;
        logic [ID_W-1:0]       tail;
    } level_t;

    typedef struct packed {
        logic                  valid;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
    } meta_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_OT_RD, S_CHECK, S_SCAN_RD, S_SCAN_CMP,
        S_APPEND, S_FINISH, S_INS_CHK, S_SHD_RD, S_SHD_WR, S_INSERT,
        S_UNLINK, S_SHU_CHK, S_SHU_WR, S_TOP_B, S_TOP_A, S_TOP_C, S_DONE
    } lob_state_t;

endpackage

>>> hdl/lob_core.sv
`include "limit_order_book_levels_top_defines.svh"

module lob_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lob_pkg::in_item_t in_item,
    output logic              res_valid,
    input  logic              res_ready,
    output lob_pkg::out_item_t res_item
);

    localparam int LA_W = lob_pkg::LVL_W + 1;

    lob_pkg::lob_state_t state_reg, state_next;
    lob_pkg::in_item_t   item_reg, item_next;
    logic                side_reg, side_next;
    logic [lob_pkg::PRICE_BITS-1:0] price_reg, price_next;
    logic [lob_pkg::LCNT_W-1:0] idx_reg, idx_next, jdx_reg, jdx_next;
    logic [lob_pkg::LCNT_W-1:0] bid_n_reg, bid_n_next, ask_n_reg, ask_n_next, n_cur;
    logic [lob_pkg::ID_W-1:0] o_prev_reg, o_prev_next, o_next_reg, o_next_next;
    logic [lob_pkg::ID_W-1:0] clr_reg, clr_next;
    lob_pkg::level_t lvl_reg, lvl_next, bid_top_reg, bid_top_next, ask_top_reg, ask_top_next;
    logic [1:0] status_reg, status_next;

    // order table, split by field so each field has its own write port
    lob_pkg::meta_t meta_mem [lob_pkg::ORDER_SLOTS];
    logic [lob_pkg::ID_W-1:0] prev_mem [lob_pkg::ORDER_SLOTS];
    logic [lob_pkg::ID_W-1:0] next_mem [lob_pkg::ORDER_SLOTS];
    lob_pkg::level_t lvl_mem [2*lob_pkg::LEVELS_PER_SIDE];

    lob_pkg::meta_t meta_q, meta_wd;
    logic [lob_pkg::ID_W-1:0] prev_q, next_q;
    logic meta_we, prev_we, next_we, lvl_we;
    logic [lob_pkg::ID_W-1:0] meta_wa, prev_wa, next_wa, prev_wd, next_wd;
    logic [LA_W-1:0] lvl_wa, lvl_ra;
    lob_pkg::level_t lvl_wd, lvl_q, lvl_upd;
    logic ahead;
    logic [lob_pkg::LCNT_W-1:0] jdx_inc;
    logic [lob_pkg::QCNT_W-1:0] cnt_dec;

    always_ff @(posedge aclk) begin
        if (meta_we) meta_mem[meta_wa] <= meta_wd;
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        if (next_we) next_mem[next_wa] <= next_wd;
        meta_q <= meta_mem[item_reg.order_id];
        prev_q <= prev_mem[item_reg.order_id];
        next_q <= next_mem[item_reg.order_id];
    end

    always_ff @(posedge aclk) begin
        if (lvl_we) lvl_mem[lvl_wa] <= lvl_wd;
        lvl_q <= lvl_mem[lvl_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lob_pkg::S_CLEAR;
            clr_reg   <= '0;
            bid_n_reg <= '0;
            ask_n_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            bid_n_reg <= bid_n_next;
            ask_n_reg <= ask_n_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        side_reg    <= side_next;
        price_reg   <= price_next;
        idx_reg     <= idx_next;
        jdx_reg     <= jdx_next;
        o_prev_reg  <= o_prev_next;
        o_next_reg  <= o_next_next;
        lvl_reg     <= lvl_next;
        bid_top_reg <= bid_top_next;
        ask_top_reg <= ask_top_next;
        status_reg  <= status_next;
    end

    assign n_cur   = side_reg ? ask_n_reg : bid_n_reg;
    assign ahead   = side_reg ? (lvl_q.price < price_reg) : (lvl_q.price > price_reg);
    assign jdx_inc = jdx_reg + lob_pkg::LCNT_W'(1);
    assign cnt_dec = (lvl_reg.count != '0) ? lvl_reg.count - lob_pkg::QCNT_W'(1) : '0;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        side_next    = side_reg;
        price_next   = price_reg;
        idx_next     = idx_reg;
        jdx_next     = jdx_reg;
        bid_n_next   = bid_n_reg;
        ask_n_next   = ask_n_reg;
        o_prev_next  = o_prev_reg;
        o_next_next  = o_next_reg;
        clr_next     = clr_reg;
        lvl_next     = lvl_reg;
        bid_top_next = bid_top_reg;
        ask_top_next = ask_top_reg;
        status_next  = status_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        meta_we = 1'b0; meta_wa = item_reg.order_id;
        meta_wd = '{valid: 1'b0, side: side_reg, price: price_reg};
        prev_we = 1'b0; prev_wa = item_reg.order_id; prev_wd = '0;
        next_we = 1'b0; next_wa = item_reg.order_id; next_wd = '0;
        lvl_we  = 1'b0; lvl_wa = {side_reg, idx_reg[lob_pkg::LVL_W-1:0]}; lvl_wd = lvl_q;
        lvl_ra  = {side_reg, idx_reg[lob_pkg::LVL_W-1:0]};
        lvl_upd = lvl_reg;

        case (state_reg)
            lob_pkg::S_CLEAR: begin
                meta_we  = 1'b1;
                meta_wa  = clr_reg;
                meta_wd  = '0;
                clr_next = clr_reg + lob_pkg::ID_W'(1);
                if (clr_reg == lob_pkg::ID_W'(lob_pkg::ORDER_SLOTS - 1))
                    state_next = lob_pkg::S_IDLE;
            end
            lob_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    item_next  = in_item;
                    state_next = lob_pkg::S_OT_RD;
                end
            end
            lob_pkg::S_OT_RD: state_next = lob_pkg::S_CHECK;
            lob_pkg::S_CHECK: begin
                idx_next = '0;
                if (item_reg.kind == lob_pkg::KIND_ADD) begin
                    side_next  = item_reg.side;
                    price_next = item_reg.price;
                    if (meta_q.valid) begin
                        status_next = lob_pkg::ST_DUP;
                        state_next  = lob_pkg::S_TOP_B;
                    end else begin
                        state_next = lob_pkg::S_SCAN_RD;
                    end
                end else begin
                    side_next   = meta_q.side;
                    price_next  = meta_q.price;
                    o_prev_next = prev_q;
                    o_next_next = next_q;
                    if (!meta_q.valid) begin
                        status_next = lob_pkg::ST_UNKNOWN;
                        state_next  = lob_pkg::S_TOP_B;
                    end else begin
                        state_next = lob_pkg::S_SCAN_RD;
                    end
                end
            end
            lob_pkg::S_SCAN_RD: begin
                if (idx_reg < n_cur) begin
                    state_next = lob_pkg::S_SCAN_CMP;
                end else if (item_reg.kind == lob_pkg::KIND_ADD) begin
                    state_next = lob_pkg::S_INS_CHK;
                end else begin
                    // live order whose level is gone: just drop it
                    meta_we     = 1'b1;
                    status_next = lob_pkg::ST_OK;
                    state_next  = lob_pkg::S_TOP_B;
                end
            end
            lob_pkg::S_SCAN_CMP: begin
                if (item_reg.kind == lob_pkg::KIND_ADD) begin
                    if (ahead) begin
                        idx_next   = idx_reg + lob_pkg::LCNT_W'(1);
                        state_next = lob_pkg::S_SCAN_RD;
                    end else if (lvl_q.price == price_reg) begin
                        lvl_next   = lvl_q;
                        state_next = lob_pkg::S_APPEND;
                    end else begin
                        state_next = lob_pkg::S_INS_CHK;
                    end
                end else if (lvl_q.price == price_reg) begin
                    lvl_next   = lvl_q;
                    state_next = lob_pkg::S_UNLINK;
                end else begin
                    idx_next   = idx_reg + lob_pkg::LCNT_W'(1);
                    state_next = lob_pkg::S_SCAN_RD;
                end
            end
            lob_pkg::S_APPEND: begin
                next_we = 1'b1;
                next_wa = lvl_reg.tail;
                next_wd = item_reg.order_id;
                prev_we = 1'b1;
                prev_wd = lvl_reg.tail;
                lvl_upd.tail  = item_reg.order_id;
                lvl_upd.count = lvl_reg.count + lob_pkg::QCNT_W'(1);
                lvl_we = 1'b1;
                lvl_wd = lvl_upd;
                state_next = lob_pkg::S_FINISH;
            end
            lob_pkg::S_FINISH: begin
                next_we = 1'b1;
                meta_we = 1'b1;
                meta_wd.valid = 1'b1;
                status_next = lob_pkg::ST_OK;
                state_next  = lob_pkg::S_TOP_B;
            end
            lob_pkg::S_INS_CHK: begin
                jdx_next = n_cur;
                if (n_cur >= lob_pkg::LCNT_W'(lob_pkg::LEVELS_PER_SIDE)) begin
                    status_next = lob_pkg::ST_FULL;
                    state_next  = lob_pkg::S_TOP_B;
                end else if (n_cur > idx_reg) begin
                    state_next = lob_pkg::S_SHD_RD;
                end else begin
                    state_next = lob_pkg::S_INSERT;
                end
            end
            lob_pkg::S_SHD_RD: begin
                lvl_ra = {side_reg, jdx_reg[lob_pkg::LVL_W-1:0] - lob_pkg::LVL_W'(1)};
                state_next = lob_pkg::S_SHD_WR;
            end
            lob_pkg::S_SHD_WR: begin
                // move one level down to open the slot
                lvl_we   = 1'b1;
                lvl_wa   = {side_reg, jdx_reg[lob_pkg::LVL_W-1:0]};
                jdx_next = jdx_reg - lob_pkg::LCNT_W'(1);
                state_next = (jdx_reg - lob_pkg::LCNT_W'(1) > idx_reg) ?
                             lob_pkg::S_SHD_RD : lob_pkg::S_INSERT;
            end
            lob_pkg::S_INSERT: begin
                lvl_we = 1'b1;
                lvl_wd = '{price: price_reg, count: lob_pkg::QCNT_W'(1),
                           head: item_reg.order_id, tail: item_reg.order_id};
                prev_we = 1'b1;
                next_we = 1'b1;
                meta_we = 1'b1;
                meta_wd.valid = 1'b1;
                if (side_reg) ask_n_next = ask_n_reg + lob_pkg::LCNT_W'(1);
                else          bid_n_next = bid_n_reg + lob_pkg::LCNT_W'(1);
                status_next = lob_pkg::ST_OK;
                state_next  = lob_pkg::S_TOP_B;
            end
            lob_pkg::S_UNLINK: begin
                if (lvl_reg.head == item_reg.order_id) begin
                    lvl_upd.head = o_next_reg;
                end else begin
                    next_we = 1'b1;
                    next_wa = o_prev_reg;
                    next_wd = o_next_reg;
                end
                if (lvl_reg.tail == item_reg.order_id) begin
                    lvl_upd.tail = o_prev_reg;
                end else begin
                    prev_we = 1'b1;
                    prev_wa = o_next_reg;
                    prev_wd = o_prev_reg;
                end
                lvl_upd.count = cnt_dec;
                meta_we     = 1'b1;
                status_next = lob_pkg::ST_OK;
                jdx_next    = idx_reg;
                if (cnt_dec != '0) begin
                    lvl_we = 1'b1;
                    lvl_wd = lvl_upd;
                    state_next = lob_pkg::S_TOP_B;
                end else begin
                    state_next = lob_pkg::S_SHU_CHK;
                end
            end
            lob_pkg::S_SHU_CHK: begin
                lvl_ra = {side_reg, jdx_inc[lob_pkg::LVL_W-1:0]};
                if (jdx_inc < n_cur) begin
                    state_next = lob_pkg::S_SHU_WR;
                end else begin
                    if (side_reg) ask_n_next = ask_n_reg - lob_pkg::LCNT_W'(1);
                    else          bid_n_next = bid_n_reg - lob_pkg::LCNT_W'(1);
                    state_next = lob_pkg::S_TOP_B;
                end
            end
            lob_pkg::S_SHU_WR: begin
                // close the gap left by the emptied level
                lvl_we   = 1'b1;
                lvl_wa   = {side_reg, jdx_reg[lob_pkg::LVL_W-1:0]};
                jdx_next = jdx_inc;
                state_next = lob_pkg::S_SHU_CHK;
            end
            lob_pkg::S_TOP_B: begin
                lvl_ra = {lob_pkg::SIDE_BID, lob_pkg::LVL_W'(0)};
                state_next = lob_pkg::S_TOP_A;
            end
            lob_pkg::S_TOP_A: begin
                lvl_ra = {lob_pkg::SIDE_ASK, lob_pkg::LVL_W'(0)};
                bid_top_next = lvl_q;
                state_next = lob_pkg::S_TOP_C;
            end
            lob_pkg::S_TOP_C: begin
                ask_top_next = lvl_q;
                state_next = lob_pkg::S_DONE;
            end
            lob_pkg::S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) state_next = lob_pkg::S_IDLE;
            end
            default: state_next = lob_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        res_item = '0;
        res_item.status = status_reg;
        if (bid_n_reg != '0) begin
            res_item.bid_valid      = 1'b1;
            res_item.best_bid_price = bid_top_reg.price;
            res_item.best_bid_count = bid_top_reg.count;
            res_item.best_bid_head  = bid_top_reg.head;
        end
        if (ask_n_reg != '0) begin
            res_item.ask_valid      = 1'b1;
            res_item.best_ask_price = ask_top_reg.price;
            res_item.best_ask_count = ask_top_reg.count;
            res_item.best_ask_head  = ask_top_reg.head;
        end
    end

    `LOB_ASSERT(a_lvl_bound, (bid_n_reg <= lob_pkg::LCNT_W'(lob_pkg::LEVELS_PER_SIDE)) && (ask_n_reg <= lob_pkg::LCNT_W'(lob_pkg::LEVELS_PER_SIDE)), "level count out of range")
    `LOB_ASSERT(a_accept_flow, (in_valid && in_ready) |=> (state_reg == lob_pkg::S_OT_RD), "accepted beat not processed")
    `LOB_ASSERT(a_bid_n_step, (bid_n_reg != $past(bid_n_reg)) |-> ($past(state_reg) == lob_pkg::S_INSERT || $past(state_reg) == lob_pkg::S_SHU_CHK), "bid level count changed outside insert or remove")
    `LOB_ASSERT(a_no_accept_clear, (state_reg == lob_pkg::S_CLEAR) |-> !in_ready, "beat taken during table clear")

endmodule

>>> hdl/limit_order_book_levels_top.sv
// flow: the order entry is fetched, then the price levels are scanned, levels are moved on
// insert or removal, then both best levels are read and the result goes into the output register
// throughput: one item at a time over the single-port level memory; a new beat is taken only
// after the last result has gone into the output register, so an output stall holds the core
// reset: aresetn synchronous active low; after release a sweep clears the order table valid
// flags, and no beat is taken until it ends
module limit_order_book_levels_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lob_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output lob_pkg::out_item_t m_item
);

    logic               res_valid, res_ready;
    lob_pkg::out_item_t res_item;
    logic               out_valid_reg, out_valid_next;
    lob_pkg::out_item_t out_reg, out_next;

    lob_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // output register frees the core while the result waits
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_ready) out_valid_next = 1'b0;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_next       = res_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int IDS      = 4096;
    localparam int NLVL     = lob_pkg::LEVELS_PER_SIDE;
    localparam int WDOG_MAX = 20000;
    localparam int RAND_N   = 1000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    lob_pkg::in_item_t  s_item;
    logic               m_valid;
    logic               m_ready;
    lob_pkg::out_item_t m_item;

    limit_order_book_levels_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // book shadow
    logic            ord_live [IDS];
    logic            ord_side [IDS];
    logic [15:0]     ord_px   [IDS];
    logic [11:0]     ord_prev [IDS];
    logic [11:0]     ord_next [IDS];
    lob_pkg::level_t lvl      [2][NLVL];
    int              nlvl     [2];

    lob_pkg::out_item_t book_q[$];
    int                 errors;
    int                 beats_out;
    bit                 hold_off;
    bit                 no_idle;
    bit                 feed_done;
    bit                 pin_exp[$];
    lob_pkg::out_item_t pin_val[$];

    function automatic logic [1:0] book_add(logic [11:0] id, logic sd, logic [15:0] p);
        int i;
        logic [11:0] t;
        i = 0;
        if (ord_live[id]) return lob_pkg::ST_DUP;
        while (i < nlvl[sd] && (sd == lob_pkg::SIDE_ASK ? lvl[sd][i].price < p
                                                        : lvl[sd][i].price > p)) i++;
        if (i < nlvl[sd] && lvl[sd][i].price == p) begin
            t = lvl[sd][i].tail;
            ord_next[t] = id;
            ord_prev[id] = t;
            lvl[sd][i].tail = id;
            lvl[sd][i].count = 13'(lvl[sd][i].count + 13'd1);
        end else begin
            if (nlvl[sd] >= NLVL) return lob_pkg::ST_FULL;
            for (int k = nlvl[sd]; k > i; k--) lvl[sd][k] = lvl[sd][k-1];
            lvl[sd][i].price = p;
            lvl[sd][i].count = 13'd1;
            lvl[sd][i].head = id;
            lvl[sd][i].tail = id;
            nlvl[sd]++;
            ord_prev[id] = '0;
        end
        ord_live[id] = 1'b1;
        ord_side[id] = sd;
        ord_px[id]   = p;
        ord_next[id] = '0;
        return lob_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] book_cancel(logic [11:0] id);
        int i;
        logic sd;
        i = 0;
        if (!ord_live[id]) return lob_pkg::ST_UNKNOWN;
        sd = ord_side[id];
        while (i < nlvl[sd] && lvl[sd][i].price != ord_px[id]) i++;
        if (i >= nlvl[sd]) begin
            ord_live[id] = 1'b0;
            return lob_pkg::ST_OK;
        end
        if (lvl[sd][i].head == id) lvl[sd][i].head = ord_next[id];
        else ord_next[ord_prev[id]] = ord_next[id];
        if (lvl[sd][i].tail == id) lvl[sd][i].tail = ord_prev[id];
        else ord_prev[ord_next[id]] = ord_prev[id];
        if (lvl[sd][i].count > 0) lvl[sd][i].count = 13'(lvl[sd][i].count - 13'd1);
        if (lvl[sd][i].count == 0) begin
            for (int k = i; k < nlvl[sd] - 1; k++) lvl[sd][k] = lvl[sd][k+1];
            nlvl[sd]--;
        end
        ord_live[id] = 1'b0;
        return lob_pkg::ST_OK;
    endfunction

    function automatic lob_pkg::out_item_t book_apply(lob_pkg::in_item_t it);
        lob_pkg::out_item_t r;
        r = '0;
        r.status = (it.kind == lob_pkg::KIND_CANCEL) ? book_cancel(it.order_id)
                                                     : book_add(it.order_id, it.side, it.price);
        if (nlvl[lob_pkg::SIDE_BID] > 0) begin
            r.bid_valid      = 1'b1;
            r.best_bid_price = lvl[lob_pkg::SIDE_BID][0].price;
            r.best_bid_count = lvl[lob_pkg::SIDE_BID][0].count;
            r.best_bid_head  = lvl[lob_pkg::SIDE_BID][0].head;
        end
        if (nlvl[lob_pkg::SIDE_ASK] > 0) begin
            r.ask_valid      = 1'b1;
            r.best_ask_price = lvl[lob_pkg::SIDE_ASK][0].price;
            r.best_ask_count = lvl[lob_pkg::SIDE_ASK][0].count;
            r.best_ask_head  = lvl[lob_pkg::SIDE_ASK][0].head;
        end
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // issue one beat and queue its expectation
    task automatic send_order(lob_pkg::in_item_t it, bit pin, lob_pkg::out_item_t want);
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book_q.push_back(book_apply(it));
        pin_exp.push_back(pin);
        pin_val.push_back(want);
        if (no_idle) return;
        while ($urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    function automatic lob_pkg::in_item_t mk(logic k, int id, logic sd, int p);
        lob_pkg::in_item_t it;
        it.kind = k;
        it.order_id = 12'(id);
        it.side = sd;
        it.price = 16'(p);
        return it;
    endfunction

    function automatic lob_pkg::out_item_t mk_res(logic [1:0] st, logic bv, int bp, int bc,
                                                  int bh, logic av, int ap, int ac, int ah);
        lob_pkg::out_item_t r;
        r = {st, bv, 16'(bp), 13'(bc), 12'(bh), av, 16'(ap), 13'(ac), 12'(ah)};
        return r;
    endfunction

    // directed table: stimulus, pin flag, typed expectation
    lob_pkg::in_item_t  dir_in[$];
    bit                 dir_pin[$];
    lob_pkg::out_item_t dir_res[$];

    task automatic row(lob_pkg::in_item_t it, bit pin, lob_pkg::out_item_t r);
        dir_in.push_back(it);
        dir_pin.push_back(pin);
        dir_res.push_back(r);
    endtask

    // random ids from a small pool keep the book deep and the cancels hitting
    function automatic lob_pkg::in_item_t rand_order();
        lob_pkg::in_item_t it;
        int pick;
        pick = $urandom_range(99);
        it.order_id = (pick < 85) ? 12'($urandom_range(0, 95)) : 12'($urandom);
        it.kind  = ($urandom_range(99) < 40) ? lob_pkg::KIND_CANCEL : lob_pkg::KIND_ADD;
        it.side  = 1'($urandom_range(1));
        if ($urandom_range(99) < 80)
            it.price = 16'(32768 + (it.side ? 1 : -1) * $urandom_range(0, 40));
        else
            it.price = 16'($urandom);
        return it;
    endfunction

    initial begin
        for (int i = 0; i < IDS; i++) begin
            ord_live[i] = 1'b0;
            ord_next[i] = '0;
            ord_prev[i] = '0;
        end
        nlvl[0] = 0;
        nlvl[1] = 0;
        errors    = 0;
        feed_done = 1'b0;
        no_idle   = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        row(mk(lob_pkg::KIND_CANCEL, 5, lob_pkg::SIDE_BID, 0), 1,
            mk_res(lob_pkg::ST_UNKNOWN, 0, 0, 0, 0, 0, 0, 0, 0));
        row(mk(lob_pkg::KIND_ADD, 0, lob_pkg::SIDE_BID, 0), 1,
            mk_res(lob_pkg::ST_OK, 1, 0, 1, 0, 0, 0, 0, 0));
        row(mk(lob_pkg::KIND_ADD, 4095, lob_pkg::SIDE_ASK, 65535), 1,
            mk_res(lob_pkg::ST_OK, 1, 0, 1, 0, 1, 65535, 1, 4095));
        row(mk(lob_pkg::KIND_ADD, 4095, lob_pkg::SIDE_BID, 7), 1,
            mk_res(lob_pkg::ST_DUP, 1, 0, 1, 0, 1, 65535, 1, 4095));
        row(mk(lob_pkg::KIND_ADD, 10, lob_pkg::SIDE_BID, 65535), 1,
            mk_res(lob_pkg::ST_OK, 1, 65535, 1, 10, 1, 65535, 1, 4095));
        row(mk(lob_pkg::KIND_ADD, 11, lob_pkg::SIDE_BID, 65535), 0, '0);
        row(mk(lob_pkg::KIND_ADD, 12, lob_pkg::SIDE_ASK, 0), 0, '0);
        row(mk(lob_pkg::KIND_ADD, 13, lob_pkg::SIDE_ASK, 0), 0, '0);
        row(mk(lob_pkg::KIND_ADD, 14, lob_pkg::SIDE_ASK, 100), 0, '0);
        row(mk(lob_pkg::KIND_CANCEL, 10, lob_pkg::SIDE_ASK, 9), 0, '0);
        row(mk(lob_pkg::KIND_CANCEL, 13, lob_pkg::SIDE_BID, 1), 0, '0);
        row(mk(lob_pkg::KIND_CANCEL, 12, lob_pkg::SIDE_BID, 1), 0, '0);
        row(mk(lob_pkg::KIND_CANCEL, 12, lob_pkg::SIDE_BID, 1), 0, '0);
        row(mk(lob_pkg::KIND_CANCEL, 11, lob_pkg::SIDE_BID, 0), 0, '0);
        row(mk(lob_pkg::KIND_CANCEL, 0, lob_pkg::SIDE_BID, 0), 0, '0);
        row(mk(lob_pkg::KIND_CANCEL, 4095, lob_pkg::SIDE_ASK, 0), 0, '0);
        row(mk(lob_pkg::KIND_CANCEL, 14, lob_pkg::SIDE_ASK, 0), 1,
            mk_res(lob_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < dir_in.size(); i++)
            send_order(dir_in[i], dir_pin[i], dir_res[i]);

        // fill the ask side to its level limit, then one more level
        for (int i = 0; i < NLVL; i++)
            send_order(mk(lob_pkg::KIND_ADD, 200 + i, lob_pkg::SIDE_ASK, 1000 + i), 0, '0);
        send_order(mk(lob_pkg::KIND_ADD, 300, lob_pkg::SIDE_ASK, 5000), 0, '0);
        send_order(mk(lob_pkg::KIND_ADD, 301, lob_pkg::SIDE_ASK, 1063), 0, '0);
        for (int i = 0; i < NLVL; i++)
            send_order(mk(lob_pkg::KIND_CANCEL, 200 + i, lob_pkg::SIDE_BID, 0), 0, '0);
        send_order(mk(lob_pkg::KIND_CANCEL, 301, lob_pkg::SIDE_BID, 0), 0, '0);

        for (int i = 0; i < RAND_N; i++) begin
            no_idle = (i >= 400 && i < 550);
            send_order(rand_order(), 0, '0);
        end
        s_valid   <= 1'b0;
        feed_done <= 1'b1;
    end

    // receiver: random stalls, one long hold-off, a clean stretch
    initial begin
        m_ready  = 1'b0;
        hold_off = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (beats_out == 300 && !hold_off) begin
                hold_off = 1'b1;
                m_ready <= 1'b0;
                repeat (2000) @(posedge aclk);
            end
            if (beats_out >= 400 && beats_out < 550) m_ready <= 1'b1;
            else m_ready <= ($urandom_range(99) >= 32);
        end
    end

    // checker
    initial begin
        lob_pkg::out_item_t want;
        bit pin;
        lob_pkg::out_item_t pv;
        beats_out = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                beats_out++;
                if (book_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, m_item);
                    errors++;
                end else begin
                    want = book_q.pop_front();
                    pin  = pin_exp.pop_front();
                    pv   = pin_val.pop_front();
                    if (pin && pv != want) begin
                        $display("%0t: table row expected %h, predictor %h",
                                 $realtime, pv, want);
                        errors++;
                    end
                    if (m_item.status != want.status ||
                        m_item.bid_valid != want.bid_valid ||
                        m_item.best_bid_price != want.best_bid_price ||
                        m_item.best_bid_count != want.best_bid_count ||
                        m_item.best_bid_head != want.best_bid_head ||
                        m_item.ask_valid != want.ask_valid ||
                        m_item.best_ask_price != want.best_ask_price ||
                        m_item.best_ask_count != want.best_ask_count ||
                        m_item.best_ask_head != want.best_ask_head) begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $realtime, want, m_item);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        int idle_cyc;
        int tail;
        idle_cyc = 0;
        tail = 0;
        @(posedge aclk iff aresetn);
        repeat (4200) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cyc = 0;
            else idle_cyc++;
            if (feed_done && book_q.size() == 0) tail++;
            else tail = 0;
            if (tail >= 300) begin
                if (errors == 0) $display("** limit_order_book_levels_top: PASSED **");
                else $display("** limit_order_book_levels_top: FAILED **");
                $finish;
            end else if (idle_cyc >= WDOG_MAX) begin
                $display("%0t: timeout", $realtime);
                $display("** limit_order_book_levels_top: FAILED **");
                $finish;
            end
        end
    end

endmodule
